/* hdl/dbtp_pkg.sv */
// Shared types and constants of the device busy-timeout pool.
// Used by the controller, the datapath and the top level; depends on nothing.
package dbtp_pkg;

  localparam int unsigned DEV_W    = 4;
  localparam int unsigned DUR_W    = 16;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned PROD_W   = DUR_W + 4;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

  localparam logic REG_DEVICE_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] DEVICE_COUNT_RST = 5'd16;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } dbtp_cmd_t;

endpackage

/* hdl/dbtp_ctrl.sv */
// Controller of the device busy-timeout pool: sequences capture, lookup and commit.
// Depends on dbtp_pkg for the command struct.
module dbtp_ctrl
  import dbtp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output dbtp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign cmd_o.capture  = in_valid_i && in_ready_o;
  assign cmd_o.lookup   = (state_q == S_LOOK);
  assign cmd_o.commit   = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_o.capture) begin
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd_o.commit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/dbtp_dpath.sv */
// Datapath of the device busy-timeout pool: link table, slot use bits,
// deadline memory and result register. Depends on dbtp_pkg.
module dbtp_dpath
  import dbtp_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned DEVICE_MAX = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dbtp_cmd_t         cmd_i,
  input  logic              op_i,
  input  logic [DEV_W-1:0]  device_i,
  input  logic [DUR_W-1:0]  busy_time_i,
  input  logic [TIME_W-1:0] now_i,
  input  logic [CNT_W-1:0]  device_count_i,
  output logic [STAT_W-1:0] status_o,
  output logic              busy_res_o
);

  localparam int unsigned LinkDepth = (DEVICE_MAX < (1 << DEV_W)) ? DEVICE_MAX : (1 << DEV_W);
  localparam int unsigned LinkIdxW  = (LinkDepth > 1) ? $clog2(LinkDepth) : 1;
  localparam int unsigned LinkW     = $clog2(SLOT_COUNT + 1);
  localparam int unsigned SlotIdxW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [LinkW-1:0]    link_tab_q [LinkDepth];
  logic [SLOT_COUNT-1:0] used_q;
  logic [TIME_W-1:0]   dl_mem [SLOT_COUNT];

  logic                op_q;
  logic [DEV_W-1:0]    dev_q;
  logic [DUR_W-1:0]    dur_q;
  logic [TIME_W-1:0]   now_q;
  logic [LinkW-1:0]    link_q;
  logic                range_err_q;
  logic [TIME_W-1:0]   dl_rd_q;
  logic [TIME_W-1:0]   deadline_q;
  logic                free_found_q;
  logic [SlotIdxW-1:0] free_idx_q;
  logic [STAT_W-1:0]   status_q;
  logic                busy_q;

  logic                range_err_d;
  logic [LinkW-1:0]    link_rd;
  logic [SlotIdxW-1:0] held_idx;
  logic [PROD_W-1:0]   dur_prod;
  logic [TIME_W-1:0]   dl_sum;
  logic [TIME_W-1:0]   deadline_d;
  logic                free_found_d;
  logic [SlotIdxW-1:0] free_idx_d;

  logic                dl_we;
  logic [SlotIdxW-1:0] dl_waddr;
  logic                lt_we;
  logic [LinkW-1:0]    lt_wdata;
  logic                use_set;
  logic                use_clr;
  logic [STAT_W-1:0]   status_d;
  logic                busy_d;

  assign range_err_d = ({1'b0, device_i} >= device_count_i)
                    || (32'(device_i) >= DEVICE_MAX);
  assign link_rd     = (32'(device_i) < LinkDepth) ? link_tab_q[device_i[LinkIdxW-1:0]] : '0;
  assign held_idx    = SlotIdxW'(link_q - LinkW'(1));

  assign dur_prod    = {1'b0, dur_q, 3'b000} + {3'b000, dur_q, 1'b0};
  assign dl_sum      = now_q + TIME_W'(dur_prod);
  assign deadline_d  = (dl_sum == '0) ? TIME_W'(1) : dl_sum;

  always_comb begin
    free_found_d = 1'b0;
    free_idx_d   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found_d = 1'b1;
        free_idx_d   = SlotIdxW'(i);
      end
    end
  end

  always_comb begin
    dl_we    = 1'b0;
    dl_waddr = held_idx;
    lt_we    = 1'b0;
    lt_wdata = '0;
    use_set  = 1'b0;
    use_clr  = 1'b0;
    status_d = STATUS_OK;
    busy_d   = 1'b0;
    if (range_err_q) begin
      status_d = STATUS_RANGE;
    end else if (op_q == OP_SET) begin
      if (dur_q != '0 && link_q == '0) begin
        if (free_found_q) begin
          dl_we    = 1'b1;
          dl_waddr = free_idx_q;
          lt_we    = 1'b1;
          lt_wdata = LinkW'(free_idx_q) + LinkW'(1);
          use_set  = 1'b1;
        end else begin
          status_d = STATUS_FULL;
        end
      end else if (dur_q != '0) begin
        dl_we = 1'b1;
      end else if (link_q != '0) begin
        lt_we   = 1'b1;
        use_clr = 1'b1;
      end
    end else begin
      if (link_q != '0 && now_q > dl_rd_q) begin
        lt_we   = 1'b1;
        use_clr = 1'b1;
      end else begin
        busy_d = (link_q != '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q        <= op_i;
      dev_q       <= device_i;
      dur_q       <= busy_time_i;
      now_q       <= now_i;
      link_q      <= link_rd;
      range_err_q <= range_err_d;
    end
    if (cmd_i.lookup) begin
      deadline_q   <= deadline_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      if (link_q != '0) begin
        dl_rd_q <= dl_mem[held_idx];
      end
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      busy_q   <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && dl_we) begin
      dl_mem[dl_waddr] <= deadline_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      for (int i = 0; i < LinkDepth; i++) begin
        link_tab_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      if (use_set) begin
        used_q[free_idx_q] <= 1'b1;
      end
      if (use_clr) begin
        used_q[held_idx] <= 1'b0;
      end
      if (lt_we) begin
        link_tab_q[dev_q[LinkIdxW-1:0]] <= lt_wdata;
      end
    end
  end

  assign status_o   = status_q;
  assign busy_res_o = busy_q;

endmodule

/* hdl/device_busy_timeout_pool.sv */
// Top level of the device busy-timeout pool: configuration register and APB port.
// Instantiates dbtp_ctrl and dbtp_dpath; depends on dbtp_pkg.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_ready_o   op_i, device_i, busy_time_i, now_i
//   out      output     out_valid_o/out_ready_i status_o, busy_res_o
//   cfg      input      APB psel/penable/pready paddr, pwdata, prdata
//
// An item is accepted in the idle state and then passes through capture with the
// link table read, lookup of the held deadline and the first free slot, and commit.
// A new item is accepted only once the previous one has been committed.
// A pending result stalls only the commit; the next item is accepted while it waits.
// Reset clears the link table, the slot use bits and device_count to 16.
module device_busy_timeout_pool
  import dbtp_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned DEVICE_MAX = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [DEV_W-1:0]  device_i,
  input  logic [DUR_W-1:0]  busy_time_i,
  input  logic [TIME_W-1:0] now_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [STAT_W-1:0] status_o,
  output logic              busy_res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  dbtp_cmd_t        cmd;
  logic [CNT_W-1:0] device_count_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[APB_AW-1] == REG_DEVICE_COUNT) ? APB_DW'(device_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_count_q <= DEVICE_COUNT_RST;
    end else if (cfg_wr && paddr[APB_AW-1] == REG_DEVICE_COUNT) begin
      device_count_q <= pwdata[CNT_W-1:0];
    end
  end

  dbtp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  dbtp_dpath #(
    .SLOT_COUNT (SLOT_COUNT),
    .DEVICE_MAX (DEVICE_MAX)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op_i),
    .device_i       (device_i),
    .busy_time_i    (busy_time_i),
    .now_i          (now_i),
    .device_count_i (device_count_q),
    .status_o       (status_o),
    .busy_res_o     (busy_res_o)
  );

endmodule
